// ===== sv/rta_pkg.sv =====
// shared types and constants for the region table address translator
`timescale 1ns / 1ps

package rta_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int ADDR_W      = 32;

  // request kinds
  localparam logic [1:0] REQ_CLEAR     = 2'd0;
  localparam logic [1:0] REQ_BIND      = 2'd1;
  localparam logic [1:0] REQ_TRANSLATE = 2'd2;
  localparam logic [1:0] REQ_RESERVED  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BIND_REJECT = 2'd1;
  localparam logic [1:0] STATUS_BAD_REQ     = 2'd2;
  localparam logic [1:0] STATUS_UNMAPPED    = 2'd3;

  // sticky error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_REQ  = 2'd1;
  localparam logic [1:0] ERR_UNMAPPED = 2'd2;

  // lookup token passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] src;
  } rta_tok_t;

  // region as held by one cell: end is start plus length, delta is native minus start
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] rend;
    logic [ADDR_W-1:0] delta;
  } rta_region_t;

endpackage

// ===== sv/rta_cell.sv =====
// one table cell: holds a region and checks the passing lookup token against it
`timescale 1ns / 1ps

module rta_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rta_pkg::CNT_W-1:0] index,
  input  logic [rta_pkg::CNT_W-1:0] used,
  input  logic                      wr_en,
  input  rta_pkg::rta_region_t      wr_region,
  input  logic [rta_pkg::ADDR_W-1:0] addr,
  input  logic [rta_pkg::ADDR_W:0]  req_end,
  input  rta_pkg::rta_tok_t         tok_in,
  output rta_pkg::rta_tok_t         tok_out
);
  import rta_pkg::*;

  rta_region_t region;
  logic        hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      region <= wr_region;
    end
  end

  // first hit wins; later cells only forward
  assign hit = tok_in.valid && !tok_in.found && (index < used) &&
               (addr >= region.start) && (req_end <= {1'b0, region.rend});

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      tok_out.found <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | hit;
    end
    tok_out.src <= hit ? (addr + region.delta) : tok_in.src;
  end

endmodule

// ===== sv/region_table_address_translator_top.sv =====
// top level of the region table address translator: request decode, cell chain, result word
`timescale 1ns / 1ps

// Region table address translator. Input words carry a request kind in
// s_tuser (clear, bind, translate; the fourth code is ignored and answered
// with status ok). Every request gives exactly one result word. The table is
// a chain of MAX_REGIONS cells, one region per cell, filled in bind order.
// Clear, bind, a bad translate (null target or zero size) and the ignored
// kind are answered in the cycle after acceptance. A well-formed translate
// sends a lookup token down the cell chain, one cell per cycle, and its
// result is registered once the token leaves the last cell; the walk length
// is set by the chain depth, not by the number of bound regions. One
// request is in flight at a time: s_tready is high only while no lookup is
// walking and the result register is empty or being read.
// No clearing pass after reset; the region count alone gates the cells.

module region_table_address_translator_top (
  input  logic         clk,
  input  logic         rst,
  // input word
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // canon_address, byte_length, native_base, target_address
  input  logic [1:0]   s_tuser,  // req_type
  // result word
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // native_source, dest_out, copy_length, last_error, zero pad
  output logic [1:0]   m_tuser   // status
);
  import rta_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  // control state
  logic             state;
  logic [CNT_W-1:0] used;
  logic [1:0]       error_code;
  logic             walk_start;

  // held translate request
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] req_size;
  logic [ADDR_W-1:0] req_target;
  logic [ADDR_W:0]   req_end;

  // result register
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_src;
  logic [ADDR_W-1:0] res_dst;
  logic [ADDR_W-1:0] res_len;
  logic [1:0]        res_err;

  // input fields
  logic [1:0]        req_type;
  logic [ADDR_W-1:0] canon_address;
  logic [ADDR_W-1:0] byte_length;
  logic [ADDR_W-1:0] native_base;
  logic [ADDR_W-1:0] target_address;

  logic accept;
  logic imm_load;
  logic walk_go;
  logic bind_go;
  logic clr_go;
  logic walk_done;
  logic [1:0] imm_status;
  logic [1:0] imm_err;

  rta_region_t new_region;
  rta_tok_t    tok [0:MAX_REGIONS];

  assign req_type       = s_tuser;
  assign canon_address  = s_tdata[31:0];
  assign byte_length    = s_tdata[63:32];
  assign native_base    = s_tdata[95:64];
  assign target_address = s_tdata[127:96];

  assign s_tready  = (state == ST_IDLE) && !walk_start && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign walk_done = tok[MAX_REGIONS].valid;

  // region as stored: end and native offset precomputed at bind time
  assign new_region.start = canon_address;
  assign new_region.rend  = canon_address + byte_length;
  assign new_region.delta = native_base - canon_address;

  // request decode for the accepted word
  always_comb begin
    imm_load   = 1'b0;
    walk_go    = 1'b0;
    bind_go    = 1'b0;
    clr_go     = 1'b0;
    imm_status = STATUS_OK;
    imm_err    = error_code;
    if (accept) begin
      unique case (req_type)
        REQ_CLEAR: begin
          imm_load = 1'b1;
          clr_go   = 1'b1;
          imm_err  = ERR_NONE;
        end
        REQ_BIND: begin
          imm_load = 1'b1;
          // reject null native, empty region, full table or wrapping end
          if ((native_base == '0) || (byte_length == '0) ||
              (used >= CNT_W'(MAX_REGIONS)) || (canon_address > ~byte_length)) begin
            imm_status = STATUS_BIND_REJECT;
          end else begin
            bind_go = 1'b1;
          end
        end
        REQ_TRANSLATE: begin
          if ((target_address == '0) || (byte_length == '0)) begin
            imm_load   = 1'b1;
            imm_status = STATUS_BAD_REQ;
            imm_err    = ERR_BAD_REQ;
          end else begin
            walk_go = 1'b1;
          end
        end
        default: begin
          imm_load = 1'b1;  // reserved kind: no state change
        end
      endcase
    end
  end

  // sequencer and table count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      error_code <= ERR_NONE;
      walk_start <= 1'b0;
    end else begin
      walk_start <= walk_go;
      if (clr_go) begin
        used <= '0;
      end else if (bind_go) begin
        used <= used + CNT_W'(1);
      end
      if (imm_load) begin
        error_code <= imm_err;
      end else if (walk_done) begin
        error_code <= tok[MAX_REGIONS].found ? ERR_NONE : ERR_UNMAPPED;
      end
      unique case (state)
        ST_IDLE: begin
          if (walk_go) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the translate request while the token walks the chain
  always_ff @(posedge clk) begin
    if (walk_go) begin
      req_addr   <= canon_address;
      req_size   <= byte_length;
      req_target <= target_address;
      req_end    <= {1'b0, canon_address} + {1'b0, byte_length};
    end
  end

  // token enters the first cell as soon as the request is held, in the cycle after acceptance
  assign tok[0] = {walk_start, 1'b0, {ADDR_W{1'b0}}};

  // cell chain, one region per cell in bind order
  genvar gi;
  generate
    for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
      logic cell_wr;
      assign cell_wr = bind_go && (used == CNT_W'(gi));
      rta_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .index     (CNT_W'(gi)),
        .used      (used),
        .wr_en     (cell_wr),
        .wr_region (new_region),
        .addr      (req_addr),
        .req_end   (req_end),
        .tok_in    (tok[gi]),
        .tok_out   (tok[gi+1])
      );
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (imm_load || walk_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (imm_load) begin
      res_status <= imm_status;
      res_src    <= '0;
      res_dst    <= '0;
      res_len    <= '0;
      res_err    <= imm_err;
    end else if (walk_done) begin
      if (tok[MAX_REGIONS].found) begin
        res_status <= STATUS_OK;
        res_src    <= tok[MAX_REGIONS].src;
        res_dst    <= req_target;
        res_len    <= req_size;
        res_err    <= ERR_NONE;
      end else begin
        res_status <= STATUS_UNMAPPED;
        res_src    <= '0;
        res_dst    <= '0;
        res_len    <= '0;
        res_err    <= ERR_UNMAPPED;
      end
    end
  end

  assign m_tdata = {6'b0, res_err, res_len, res_dst, res_src};
  assign m_tuser = res_status;

endmodule
